>>> rtl/tga_rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

    // Width of the pixel counter; pixel_count is taken in its low COUNT_BITS bits
    localparam int COUNT_BITS = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RLE_ENABLED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT     = 2'd2;

    localparam logic [2:0] BPP_ALPHA = 3'd4;   // 32-bit pixels
    localparam logic [7:0] RUN_FLAG  = 8'd128; // header bytes at or above start a run
    localparam logic [7:0] RUN_BIAS  = 8'd127;

    typedef struct packed {
        logic                  rle_enabled;
        logic [2:0]            bytes_per_pixel;
        logic [CFG_DATA_W-1:0] pixel_count;
    } cfg_t;

    // One decoded pixel as it travels from the front to the back
    typedef struct packed {
        logic [7:0] byte0;      // blue
        logic [7:0] byte1;      // green
        logic [7:0] byte2;      // red
        logic [7:0] byte3;      // alpha candidate
        logic       has_alpha;
        logic [7:0] repeat_res;
        logic       last_pixel;
    } pix_rec_t;

endpackage

>>> rtl/tga_rle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_front
// Byte classifier: packet headers, colour gathering, run clipping, pixel count.
// ----------------------------------------------------------------------------
module tga_rle_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tga_rle_pkg::cfg_t      cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    output logic                   push,
    output tga_rle_pkg::pix_rec_t  push_rec,
    input  logic                   push_ready
);

    localparam int CB = tga_rle_pkg::COUNT_BITS;

    logic          awaiting_reg, awaiting_next;
    logic          run_reg, run_next;
    logic [7:0]    left_reg, left_next;
    logic [1:0]    pos_reg, pos_next;
    logic [CB-1:0] done_reg, done_next;
    logic [7:0]    color_reg [3];

    logic          accept;
    logic          rle;
    logic          bpp4;
    logic [CB-1:0] total;
    logic [CB:0]   diff;
    logic          over;
    logic [CB-1:0] rem;
    logic [7:0]    n8;
    logic [7:0]    clip;
    logic [7:0]    rep;
    logic          last;
    logic          is_header;
    logic [2:0]    pos_inc;
    logic          pix_end;

    assign accept   = in_valid & in_ready;
    assign in_ready = push_ready;
    assign rle      = cfg.rle_enabled;
    assign bpp4     = (cfg.bytes_per_pixel == tga_rle_pkg::BPP_ALPHA);

    always_comb
    begin
        total = cfg.pixel_count[CB-1:0];
        if (total == '0)
        begin
            total = {{(CB-1){1'b0}}, 1'b1};
        end
    end

    // Pixels still owed; one if the count was lowered to or below what is done
    assign diff = {1'b0, total} - {1'b0, done_reg};
    assign over = diff[CB] | (diff[CB-1:0] == '0);
    assign rem  = over ? {{(CB-1){1'b0}}, 1'b1} : diff[CB-1:0];

    assign n8   = (left_reg == 8'd0) ? 8'd1 : left_reg;
    assign clip = ({{(CB-8){1'b0}}, n8} > rem) ? rem[7:0] : n8;
    assign rep  = (rle && run_reg) ? clip : 8'd1;
    assign last = over | ({{(CB-8){1'b0}}, rep} >= rem);

    assign is_header = rle & awaiting_reg;
    assign pos_inc   = {1'b0, pos_reg} + 3'd1;
    assign pix_end   = !is_header && (pos_inc >= (bpp4 ? 3'd4 : 3'd3));

    always_comb
    begin
        awaiting_next = awaiting_reg;
        run_next      = run_reg;
        left_next     = left_reg;
        pos_next      = pos_reg;
        done_next     = done_reg;
        if (accept)
        begin
            if (is_header)
            begin
                run_next      = data_byte[7];
                left_next     = data_byte[7] ? (data_byte - tga_rle_pkg::RUN_BIAS)
                                             : (data_byte + 8'd1);
                awaiting_next = 1'b0;
                pos_next      = 2'd0;
            end
            else if (!pix_end)
            begin
                pos_next = pos_inc[1:0];
            end
            else
            begin
                pos_next = 2'd0;
                if (rle)
                begin
                    if (run_reg)
                    begin
                        left_next     = 8'd0;
                        awaiting_next = 1'b1;
                    end
                    else
                    begin
                        left_next = n8 - 8'd1;
                        if (n8 == 8'd1)
                        begin
                            awaiting_next = 1'b1;
                        end
                    end
                end
                if (last)
                begin
                    done_next     = '0;
                    awaiting_next = 1'b1;
                    run_next      = 1'b0;
                    left_next     = 8'd0;
                end
                else
                begin
                    done_next = done_reg + {{(CB-8){1'b0}}, rep};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            run_reg      <= 1'b0;
            left_reg     <= 8'd0;
            pos_reg      <= 2'd0;
            done_reg     <= '0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            run_reg      <= run_next;
            left_reg     <= left_next;
            pos_reg      <= pos_next;
            done_reg     <= done_next;
        end
    end

    // Colour bytes: no reset, slot three is never stored (alpha passes through)
    always_ff @(posedge clk)
    begin
        if (accept && !is_header && (pos_reg != 2'd3))
        begin
            color_reg[pos_reg] <= data_byte;
        end
    end

    assign push = accept & pix_end;

    always_comb
    begin
        push_rec.byte0      = color_reg[0];
        push_rec.byte1      = color_reg[1];
        push_rec.byte2      = (pos_reg == 2'd2) ? data_byte : color_reg[2];
        push_rec.byte3      = data_byte;
        push_rec.has_alpha  = bpp4;
        push_rec.repeat_res = rep;
        push_rec.last_pixel = last;
    end

endmodule

>>> rtl/tga_rle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_queue
// Two-entry pixel queue between the front and the back.
// ----------------------------------------------------------------------------
module tga_rle_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  tga_rle_pkg::pix_rec_t  push_rec,
    output logic                   push_ready,
    output logic                   pop_valid,
    output tga_rle_pkg::pix_rec_t  pop_rec,
    input  logic                   pop
);

    tga_rle_pkg::pix_rec_t mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_rec    = mem_reg[rd_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & pop_valid;

    always_comb
    begin
        wr_next  = do_push ? ~wr_reg : wr_reg;
        rd_next  = do_pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_rec;
        end
    end

endmodule

>>> rtl/tga_rle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_back
// Output stage: reorders to RGBA, masks alpha, holds the result register.
// ----------------------------------------------------------------------------
module tga_rle_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pop_valid,
    input  tga_rle_pkg::pix_rec_t               pop_rec,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tga_rle_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                                m_tlast
);

    logic                               valid_reg, valid_next;
    logic [tga_rle_pkg::OUT_DATA_W-1:0] data_reg, data_next;
    logic                               last_reg, last_next;
    logic                               load;

    assign load = pop_valid & (!valid_reg | m_tready);
    assign pop  = load;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        data_next = {pop_rec.repeat_res,
                     pop_rec.has_alpha ? pop_rec.byte3 : 8'd0,
                     pop_rec.byte0,
                     pop_rec.byte1,
                     pop_rec.byte2};
        last_next = pop_rec.last_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Truecolor TGA pixel-data decoder, raw or run-length, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* carries the image's pixel-data bytes, one byte per item. In run-length
//    mode each packet opens with a header byte; colour bytes arrive B, G, R(, A).
//  - m_* gives one item per decoded pixel or run: R, G, B, A, repeat count,
//    and tlast on the item that completes the image. The next byte then
//    starts a new image.
//  - cfg_* writes rle_enabled (0), bytes_per_pixel (1), pixel_count (2);
//    other indexes are dropped. Write only while the decoder is idle.
// Throughput: one byte per cycle while the queue has room (s_tready follows the
//  queue); a pixel takes 3 or 4 bytes.
// Path: a result is written into the queue, then loaded into the output
//  register that drives m_*.
// Stall: a stalled m_* side fills the two-entry queue; s_tready drops only when
//  the queue is full, so three results can be held back (two queued, one output).
// Reset: decoder waits for a packet header, pixel count cleared, registers at
//  rle_enabled=1, bytes_per_pixel=3, pixel_count=1. No clearing pass.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tga_rle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data,
    // byte input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] data_byte
    // pixel output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_res
    output logic [tga_rle_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                                m_tlast    // last_pixel
);

    tga_rle_pkg::cfg_t     cfg_reg, cfg_next;
    tga_rle_pkg::pix_rec_t push_rec, pop_rec;
    logic                  push, push_ready;
    logic                  pop, pop_valid;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                tga_rle_pkg::CFG_RLE_ENABLED:     cfg_next.rle_enabled     = cfg_data[0];
                tga_rle_pkg::CFG_BYTES_PER_PIXEL: cfg_next.bytes_per_pixel = cfg_data[2:0];
                tga_rle_pkg::CFG_PIXEL_COUNT:     cfg_next.pixel_count     = cfg_data;
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rle_enabled     <= 1'b1;
            cfg_reg.bytes_per_pixel <= 3'd3;
            cfg_reg.pixel_count     <= {{(tga_rle_pkg::CFG_DATA_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: headers, colour gathering, clipping and pixel counting
    tga_rle_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .data_byte  (s_tdata),
        .push       (push),
        .push_rec   (push_rec),
        .push_ready (push_ready)
    );

    // Short queue so the two sides stall independently
    tga_rle_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_rec    (pop_rec),
        .pop        (pop)
    );

    // Back: RGBA formatting and output register
    tga_rle_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_rec   (pop_rec),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
